[rtl/core/additive_unit_checksum_defines.svh]
// assertion macros for the additive unit checksum checker
`ifndef ADDITIVE_UNIT_CHECKSUM_DEFINES_SVH
`define ADDITIVE_UNIT_CHECKSUM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AUC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("auc checker: same-cycle check failed");

// next-cycle implication, checked outside reset
`define AUC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("auc checker: next-cycle check failed");

`endif

[rtl/core/auc_pkg.sv]
// shared types and codes of the additive unit checksum
`timescale 1ns / 1ps

package auc_pkg;

  // unit and checksum size codes; code 3 acts as 32 bits
  typedef enum logic [1:0] {
    SIZE_8  = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_32 = 2'd2
  } auc_size_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_UNIT_SIZE  = 3'd0,
    REG_SUM_WIDTH  = 3'd1,
    REG_BIG_ENDIAN = 3'd2,
    REG_CHECK_REM  = 3'd3,
    REG_CARRY_FOLD = 3'd4
  } auc_reg_e;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 2;

  typedef struct packed {
    logic [1:0] unit_size_code;
    logic [1:0] sum_width_code;
    logic       big_endian;
    logic       check_remainder;
    logic       carry_fold;
  } auc_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } auc_in_t;

  typedef struct packed {
    logic [31:0] checksum;
    logic        remainder_error;
  } auc_out_t;

endpackage

[rtl/core/auc_cfg_regs.sv]
// configuration register file of the additive unit checksum
`timescale 1ns / 1ps

module auc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [auc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [auc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output auc_pkg::auc_cfg_t             cfg_o
);

  auc_pkg::auc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        auc_pkg::REG_UNIT_SIZE:  cfg_d.unit_size_code  = cfg_wdata_i;
        auc_pkg::REG_SUM_WIDTH:  cfg_d.sum_width_code  = cfg_wdata_i;
        auc_pkg::REG_BIG_ENDIAN: cfg_d.big_endian      = cfg_wdata_i[0];
        auc_pkg::REG_CHECK_REM:  cfg_d.check_remainder = cfg_wdata_i[0];
        auc_pkg::REG_CARRY_FOLD: cfg_d.carry_fold      = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_size_code  <= auc_pkg::SIZE_8;
      cfg_q.sum_width_code  <= auc_pkg::SIZE_32;
      cfg_q.big_endian      <= 1'b0;
      cfg_q.check_remainder <= 1'b0;
      cfg_q.carry_fold      <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/auc_fold.sv]
// end-around carry fold of a 33-bit sum down to 8, 16 or 32 bits
`timescale 1ns / 1ps

module auc_fold (
  input  logic [32:0] sum_i,
  input  logic [1:0]  width_code_i,
  output logic [31:0] fold_o
);

  logic [9:0]  f8_a;
  logic [8:0]  f8_b;
  logic [8:0]  f8_c;
  logic [16:0] f16_a;
  logic [16:0] f16_b;
  logic [16:0] f16_c;
  logic [32:0] f32_a;

  // folding keeps the value mod 2^w-1 and never reaches zero from a nonzero sum,
  // so any fold order that ends at or below the mask gives the same result
  always_comb begin
    f8_a  = 10'(sum_i[7:0]) + 10'(sum_i[15:8]) + 10'(sum_i[23:16])
          + 10'(sum_i[31:24]) + 10'(sum_i[32]);
    f8_b  = 9'(f8_a[7:0]) + 9'(f8_a[9:8]);
    f8_c  = 9'(f8_b[7:0]) + 9'(f8_b[8]);

    f16_a = 17'(sum_i[15:0]) + 17'(sum_i[31:16]) + 17'(sum_i[32]);
    f16_b = 17'(f16_a[15:0]) + 17'(f16_a[16]);
    f16_c = 17'(f16_b[15:0]) + 17'(f16_b[16]);

    f32_a = 33'(sum_i[31:0]) + 33'(sum_i[32]);

    case (width_code_i)
      auc_pkg::SIZE_8:  fold_o = {24'd0, f8_c[7:0]};
      auc_pkg::SIZE_16: fold_o = {16'd0, f16_c[15:0]};
      default:          fold_o = f32_a[31:0];
    endcase
  end

endmodule

[rtl/core/auc_accum.sv]
// unit assembly, running sum and result forming of the checksum
`timescale 1ns / 1ps

module auc_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  auc_pkg::auc_in_t   item_i,
  input  auc_pkg::auc_cfg_t  cfg_i,
  output auc_pkg::auc_out_t  result_o
);

  logic [31:0] sum_q, sum_d;
  logic [31:0] buf_q, buf_d;
  logic [1:0]  pos_q, pos_d;

  logic [1:0]  last_pos;
  logic [31:0] buf_new;
  logic [31:0] unit_val;
  logic [32:0] sum_wide;
  logic [31:0] sum_fold;
  logic [31:0] sum_new;
  logic [31:0] width_mask;
  logic        unit_done;
  logic        partial;
  logic        rem_err;

  auc_fold u_fold (
    .sum_i        (sum_wide),
    .width_code_i (cfg_i.sum_width_code),
    .fold_o       (sum_fold)
  );

  always_comb begin
    case (cfg_i.unit_size_code)
      auc_pkg::SIZE_8:  last_pos = 2'd0;
      auc_pkg::SIZE_16: last_pos = 2'd1;
      default:          last_pos = 2'd3;
    endcase

    case (pos_q)
      2'd0:    buf_new = buf_q | {24'd0, item_i.data_byte};
      2'd1:    buf_new = buf_q | {16'd0, item_i.data_byte, 8'd0};
      2'd2:    buf_new = buf_q | {8'd0, item_i.data_byte, 16'd0};
      default: buf_new = buf_q | {item_i.data_byte, 24'd0};
    endcase

    // a unit also closes early when the size shrank below the current position
    unit_done = (pos_q >= last_pos) || item_i.last_byte;
    partial   = item_i.last_byte && (pos_q < last_pos);

    case (cfg_i.unit_size_code)
      auc_pkg::SIZE_8:  unit_val = {24'd0, buf_new[7:0]};
      auc_pkg::SIZE_16: unit_val = cfg_i.big_endian ?
                                   {16'd0, buf_new[7:0], buf_new[15:8]} :
                                   {16'd0, buf_new[15:0]};
      default:          unit_val = cfg_i.big_endian ?
                                   {buf_new[7:0], buf_new[15:8], buf_new[23:16],
                                    buf_new[31:24]} :
                                   buf_new;
    endcase

    sum_wide = {1'b0, sum_q} + {1'b0, unit_val};
    sum_new  = cfg_i.carry_fold ? sum_fold : sum_wide[31:0];

    case (cfg_i.sum_width_code)
      auc_pkg::SIZE_8:  width_mask = 32'h0000_00ff;
      auc_pkg::SIZE_16: width_mask = 32'h0000_ffff;
      default:          width_mask = 32'hffff_ffff;
    endcase

    rem_err = cfg_i.check_remainder && partial;
    result_o.remainder_error = rem_err;
    result_o.checksum        = rem_err ? 32'd0 : (sum_new & width_mask);

    sum_d = sum_q;
    buf_d = buf_q;
    pos_d = pos_q;
    if (step_i) begin
      if (item_i.last_byte) begin
        sum_d = 32'd0;
        buf_d = 32'd0;
        pos_d = 2'd0;
      end else if (unit_done) begin
        sum_d = sum_new;
        buf_d = 32'd0;
        pos_d = 2'd0;
      end else begin
        buf_d = buf_new;
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= 32'd0;
      buf_q <= 32'd0;
      pos_q <= 2'd0;
    end else begin
      sum_q <= sum_d;
      buf_q <= buf_d;
      pos_q <= pos_d;
    end
  end

endmodule

[rtl/core/additive_unit_checksum.sv]
// Additive unit checksum with optional end-around carry folding.
//
// Input channel: one byte per request with a last-byte mark, valid/ready.
// Output channel: one request per range (checksum and remainder error),
// valid/ready, issued only for a byte marked last.
// Config port: write enable, register index and 2-bit data; a write takes
// effect at the clock edge and is meant for times when no range is open in
// the pipe.
//
// Timing: a byte is captured in an input register, then assembled, added and
// folded into the running sum as it leaves that register. A last byte's result
// is written to the output register as the byte leaves the input register. One
// byte per cycle is sustained while no last byte waits on an untaken result;
// the add and bounded fold sit between the input and result registers.
// Reset clears the running sum, the unit buffer and the byte position and
// loads the register defaults. While the output register holds an untaken
// result, bytes that are not last keep flowing; a last byte waits in the
// input register and input ready drops until the result is taken.
`timescale 1ns / 1ps

module additive_unit_checksum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [auc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [auc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  auc_pkg::auc_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output auc_pkg::auc_out_t             out_data_o
);

  auc_pkg::auc_cfg_t cfg;
  auc_pkg::auc_out_t result;

  logic              in_valid_q, in_valid_d;
  auc_pkg::auc_in_t  in_data_q;
  logic              out_valid_q, out_valid_d;
  auc_pkg::auc_out_t out_data_q;
  logic              advance;
  logic              in_take;

  auc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  auc_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_data_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // only a last byte needs room in the output register
  assign advance    = in_valid_q &&
                      (!in_data_q.last_byte || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    if (advance && in_data_q.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
    if (advance && in_data_q.last_byte) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/core/auc_checker.sv]
// port-level checker of the additive unit checksum, bound to the top level
`timescale 1ns / 1ps
`include "additive_unit_checksum_defines.svh"

module auc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [auc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [auc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  auc_pkg::auc_in_t              in_data_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  auc_pkg::auc_out_t             out_data_o
);

  logic chk_rem_q;

  // shadow of the remainder check enable, seen from the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_rem_q <= 1'b0;
    end else if (cfg_we_i && (cfg_addr_i == auc_pkg::REG_CHECK_REM)) begin
      chk_rem_q <= cfg_wdata_i[0];
    end
  end

  `AUC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `AUC_ASSERT_NOW(a_err_zero, out_valid_o && out_data_o.remainder_error, out_data_o.checksum == 32'd0)
  `AUC_ASSERT_NOW(a_err_enabled, out_valid_o && out_data_o.remainder_error, chk_rem_q)
  `AUC_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

bind additive_unit_checksum auc_checker u_auc_checker (.*);

[tb/sv/additive_unit_checksum_test.sv]
// self-checking testbench of the additive unit checksum with a byte-level sum predictor
`timescale 1ns / 1ps

module additive_unit_checksum_test;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PhaseItems  = 230;

  // indexes past the register list, written to check they are ignored
  localparam logic [auc_pkg::CfgAddrW-1:0] AddrPastList =
    auc_pkg::CfgAddrW'(auc_pkg::REG_CARRY_FOLD) + 1'b1;
  localparam logic [auc_pkg::CfgAddrW-1:0] AddrTop = '1;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [auc_pkg::CfgAddrW-1:0] cfg_addr_i  = '0;
  logic [auc_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  auc_pkg::auc_in_t             in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  auc_pkg::auc_out_t            out_data_o;

  additive_unit_checksum dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  auc_pkg::auc_in_t  pending_bytes[$];
  auc_pkg::auc_out_t expected_sums[$];
  int unsigned error_count        = 0;
  int unsigned stall_cycles       = 0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_requests      = 0;
  int unsigned holds_served       = 0;
  int unsigned hold_left          = 0;
  logic        in_taken           = 1'b0;

  // predictor copy of the registers and of the summing state
  auc_pkg::auc_cfg_t cfg_shadow;
  logic [31:0] sum_acc    = '0;
  logic [31:0] unit_bytes = '0;
  logic [1:0]  next_pos   = '0;

  function automatic int unsigned size_bytes(logic [1:0] code);
    case (code)
      auc_pkg::SIZE_8:  return 1;
      auc_pkg::SIZE_16: return 2;
      default:          return 4;
    endcase
  endfunction

  function automatic void accumulate_byte(auc_pkg::auc_in_t req);
    int unsigned n;
    int unsigned wbits;
    logic [63:0] total;
    logic [63:0] wmask;
    logic [31:0] unit_val;
    logic        partial;
    auc_pkg::auc_out_t res;
    n       = size_bytes(cfg_shadow.unit_size_code);
    wbits   = 8 * size_bytes(cfg_shadow.sum_width_code);
    wmask   = (64'd1 << wbits) - 64'd1;
    partial = req.last_byte && (next_pos + 1 < n);
    unit_bytes |= 32'(req.data_byte) << (8 * next_pos);
    // a unit also closes early when a smaller unit size was set mid-unit
    if (next_pos + 1 >= n || req.last_byte) begin
      unit_val = '0;
      for (int unsigned i = 0; i < n; i++) begin
        if (cfg_shadow.big_endian) begin
          unit_val |= 32'(unit_bytes[8*i +: 8]) << (8 * (n - 1 - i));
        end else begin
          unit_val |= 32'(unit_bytes[8*i +: 8]) << (8 * i);
        end
      end
      total = 64'(sum_acc) + 64'(unit_val);
      if (cfg_shadow.carry_fold) begin
        while (total > wmask) total = (total & wmask) + (total >> wbits);
      end
      sum_acc    = total[31:0];
      unit_bytes = '0;
      next_pos   = '0;
    end else begin
      next_pos = next_pos + 2'd1;
    end
    if (req.last_byte) begin
      res.remainder_error = cfg_shadow.check_remainder && partial;
      res.checksum = res.remainder_error ? 32'd0 : 32'(64'(sum_acc) & wmask);
      expected_sums.push_back(res);
      sum_acc    = '0;
      unit_bytes = '0;
      next_pos   = '0;
    end
  endfunction

  always @(negedge clk_i) begin : sender
    auc_pkg::auc_in_t nxt_data;
    logic             nxt_valid;
    nxt_valid = in_valid_i;
    nxt_data  = in_data_i;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      nxt_valid = 1'b0;
      if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_data  = pending_bytes.pop_front();
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_data;
  end

  always @(negedge clk_i) begin : receiver
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    auc_pkg::auc_out_t want;
    logic              out_fire;
    in_taken = in_valid_i && in_ready_o;
    out_fire = out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (out_fire) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected result: checksum %h remainder_error %b",
                 out_data_o.checksum, out_data_o.remainder_error);
          error_count++;
        end else begin
          want = expected_sums.pop_front();
          if (out_data_o.checksum !== want.checksum) begin
            $error("checksum: expected %h, actual %h", want.checksum, out_data_o.checksum);
            error_count++;
          end
          if (out_data_o.remainder_error !== want.remainder_error) begin
            $error("remainder_error: expected %b, actual %b",
                   want.remainder_error, out_data_o.remainder_error);
            error_count++;
          end
        end
      end
      if (in_taken) accumulate_byte(in_data_i);
      if (in_taken || out_fire ||
          (pending_bytes.size() == 0 && expected_sums.size() == 0 && !in_valid_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = stall_cycles + 1;
      end
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= StallLimit);
    $display("additive_unit_checksum_test: errors");
    $finish;
  end

  task automatic write_reg(logic [auc_pkg::CfgAddrW-1:0] addr,
                           logic [auc_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    case (addr)
      auc_pkg::REG_UNIT_SIZE:  cfg_shadow.unit_size_code  = value;
      auc_pkg::REG_SUM_WIDTH:  cfg_shadow.sum_width_code  = value;
      auc_pkg::REG_BIG_ENDIAN: cfg_shadow.big_endian      = value[0];
      auc_pkg::REG_CHECK_REM:  cfg_shadow.check_remainder = value[0];
      auc_pkg::REG_CARRY_FOLD: cfg_shadow.carry_fold      = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [1:0] unit_code, logic [1:0] width_code,
                            logic [1:0] be, logic [1:0] chk, logic [1:0] fold);
    write_reg(auc_pkg::REG_UNIT_SIZE, unit_code);
    write_reg(auc_pkg::REG_SUM_WIDTH, width_code);
    write_reg(auc_pkg::REG_BIG_ENDIAN, be);
    write_reg(auc_pkg::REG_CHECK_REM, chk);
    write_reg(auc_pkg::REG_CARRY_FOLD, fold);
  endtask

  task automatic queue_byte(logic [7:0] data, logic last);
    pending_bytes.push_back('{data_byte: data, last_byte: last});
  endtask

  task automatic queue_range(int unsigned len);
    logic [7:0] data;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(7))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        default: data = 8'($urandom);
      endcase
      queue_byte(data, i == len - 1);
    end
  endtask

  // waits until every request is taken and every sum is back, then lets the pipe settle
  task automatic drain();
    do @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_sums.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic fill_items(int unsigned count);
    int unsigned queued;
    int unsigned len;
    queued = 0;
    while (queued < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
      queue_range(len);
      queued += len;
    end
  endtask

  task automatic random_phase(int unsigned idle_pct, int unsigned stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    fill_items(PhaseItems / 2);
    drain();
    fill_items(PhaseItems / 2);
    drain();
  endtask

  initial begin : stimulus
    cfg_shadow.unit_size_code  = auc_pkg::SIZE_8;
    cfg_shadow.sum_width_code  = auc_pkg::SIZE_32;
    cfg_shadow.big_endian      = 1'b0;
    cfg_shadow.check_remainder = 1'b0;
    cfg_shadow.carry_fold      = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset configuration: byte units, plain 32-bit sum, a three-byte and a single-byte range
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hA5, 1'b1);
    queue_byte(8'h7E, 1'b1);
    drain();

    // big-endian 16-bit units with folding, zero-padded trailing byte
    set_config(auc_pkg::SIZE_16, auc_pkg::SIZE_16, 2'd1, 2'd0, 2'd1);
    repeat (5) queue_byte(8'hFF, 1'b0);
    pending_bytes[$].last_byte = 1'b1;
    drain();

    // remainder checking: odd length flags, even length passes
    write_reg(auc_pkg::REG_CHECK_REM, 2'd1);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h03, 1'b1);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h34, 1'b1);
    drain();

    // 32-bit units folded into an 8-bit sum
    set_config(auc_pkg::SIZE_32, auc_pkg::SIZE_8, 2'd0, 2'd0, 2'd1);
    repeat (4) queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b1);
    drain();

    // size code 3 on both registers, masked writes, writes past the list
    set_config(2'd3, 2'd3, 2'd3, 2'd3, 2'd2);
    write_reg(AddrPastList, 2'd3);
    write_reg(AddrTop, 2'd3);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b1);
    drain();

    // unit size shrinks while three bytes of a 32-bit unit are held
    set_config(auc_pkg::SIZE_32, auc_pkg::SIZE_32, 2'd0, 2'd0, 2'd0);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'h22, 1'b0);
    queue_byte(8'h33, 1'b0);
    drain();
    write_reg(auc_pkg::REG_UNIT_SIZE, auc_pkg::SIZE_8);
    queue_byte(8'h44, 1'b1);
    drain();

    // long output hold-off while requests keep coming
    set_config(auc_pkg::SIZE_32, auc_pkg::SIZE_8, 2'd1, 2'd0, 2'd1);
    hold_requests++;
    random_phase(0, 0);
    set_config(auc_pkg::SIZE_16, auc_pkg::SIZE_16, 2'd0, 2'd1, 2'd1);
    random_phase(57, 0);
    set_config(auc_pkg::SIZE_8, auc_pkg::SIZE_32, 2'd0, 2'd0, 2'd0);
    random_phase(0, 57);
    set_config(2'd3, 2'd3, 2'd1, 2'd1, 2'd0);
    random_phase(15, 15);
    for (int unsigned p = 0; p < 4; p++) begin
      set_config(2'($urandom_range(3)), 2'($urandom_range(3)), 2'($urandom_range(3)),
                 2'($urandom_range(3)), 2'($urandom_range(3)));
      case (p)
        0:       random_phase(0, 0);
        1:       random_phase(57, 0);
        2:       random_phase(0, 57);
        default: random_phase(15, 15);
      endcase
    end

    drain();
    if (expected_sums.size() != 0) begin
      $error("%0d expected sums never arrived", expected_sums.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("additive_unit_checksum_test: clean");
    end else begin
      $display("additive_unit_checksum_test: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/auc_pkg.sv
rtl/core/auc_cfg_regs.sv
rtl/core/auc_fold.sv
rtl/core/auc_accum.sv
rtl/core/additive_unit_checksum.sv
rtl/core/auc_checker.sv
tb/sv/additive_unit_checksum_test.sv
